// File: src/tfhq_pkg.sv
// ----------------------------------------------------------------------------
// tfhq_pkg
// Shared types, constants and helpers for the floor height query block.
// ----------------------------------------------------------------------------
package tfhq_pkg;

    // configuration register indexes
    localparam logic [1:0] REG_QUERY_X       = 2'd0;
    localparam logic [1:0] REG_QUERY_Y       = 2'd1;
    localparam logic [1:0] REG_WINDOW_TOP    = 2'd2;
    localparam logic [1:0] REG_WINDOW_BOTTOM = 2'd3;

    // box margin: floor(span / 5000) = ((span >> 3) * MARGIN_MUL) >> MARGIN_SHIFT
    localparam logic [29:0] MARGIN_MUL   = 30'd879609303;
    localparam int          MARGIN_SHIFT = 39;
    localparam logic [19:0] MARGIN_ABS   = 20'd655;

    localparam logic signed [63:0] DET_MIN  = 64'sd42950;
    localparam logic signed [34:0] BARY_TOL = 35'sd107374;
    localparam logic signed [34:0] Q30_ONE  = 35'sd1073741824;
    localparam logic signed [64:0] Q30_HALF = 65'sd536870912;

    typedef enum logic [5:0] {
        OP_IDLE, OP_PREP, OP_MX, OP_MY, OP_MGY, OP_BOX,
        OP_N0, OP_N1, OP_N2, OP_N3, OP_N4, OP_N5, OP_NZ,
        OP_MAG, OP_SHIFT, OP_SQX, OP_SQY, OP_SQZ, OP_SL0, OP_SL1,
        OP_D0, OP_D1, OP_DET, OP_DCHK, OP_U1, OP_UN, OP_V1, OP_VN,
        OP_DIVU, OP_WAITU, OP_DIVV, OP_WAITV, OP_BARY,
        OP_H0, OP_H1, OP_H2, OP_H3, OP_H4, OP_UPD, OP_END
    } tfhq_op_t;

    typedef struct packed {
        tfhq_op_t op;
        logic     load;
    } tfhq_cmd_t;

    typedef struct packed {
        logic fail;
        logic shift_done;
        logic div_done;
        logic last;
        logic out_busy;
    } tfhq_stat_t;

    // difference saturated to +-(2^31 - 1)
    function automatic logic signed [31:0] dsat(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        logic signed [32:0] d;
        d = 33'(a) - 33'(b);
        if (d > 33'sd2147483647) begin
            return 32'sd2147483647;
        end else if (d < -33'sd2147483647) begin
            return -32'sd2147483647;
        end
        return d[31:0];
    endfunction

    function automatic logic [63:0] mag64(input logic signed [63:0] v);
        return v[63] ? 64'(-v) : 64'(v);
    endfunction

endpackage

// File: src/tfhq_div.sv
// ----------------------------------------------------------------------------
// tfhq_div
// Serial signed divider: num / den in Q.30, truncated toward zero, magnitude
// saturated at 4.0. One quotient bit per cycle.
// ----------------------------------------------------------------------------
module tfhq_div (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic signed [63:0] num,
    input  logic signed [63:0] den,
    output logic               done,
    output logic signed [33:0] quot
);

    logic [65:0] r_reg;
    logic [63:0] d_reg;
    logic [31:0] q_reg;
    logic [4:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic        neg_reg;
    logic        sat_reg;

    logic [65:0] r_in;
    logic [65:0] cmp;
    logic        ge;
    logic [63:0] n_mag;
    logic [63:0] d_mag;
    logic [32:0] q_mag;

    assign n_mag = tfhq_pkg::mag64(num);
    assign d_mag = tfhq_pkg::mag64(den);

    always_comb begin
        // first two steps give the integer bits, then the remainder shifts
        r_in = (cnt_reg >= 5'd2) ? {r_reg[64:0], 1'b0} : r_reg;
        cmp  = (cnt_reg == 5'd0) ? {1'b0, d_reg, 1'b0} : {2'b00, d_reg};
        ge   = (r_in >= cmp);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                r_reg    <= {2'b00, n_mag};
                d_reg    <= d_mag;
                sat_reg  <= ({2'b00, n_mag} >= {d_mag, 2'b00});
                neg_reg  <= num[63] ^ den[63];
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                r_reg   <= ge ? (r_in - cmp) : r_in;
                q_reg   <= {q_reg[30:0], ge};
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign q_mag = sat_reg ? 33'h1_0000_0000 : {1'b0, q_reg};
    assign quot  = neg_reg ? -$signed({1'b0, q_mag}) : $signed({1'b0, q_mag});
    assign done  = done_reg;

endmodule

// File: src/tfhq_ctrl.sv
// ----------------------------------------------------------------------------
// tfhq_ctrl
// Sequencer for the floor height query: walks one triangle through the
// datapath steps and drops out early when a test rejects it.
// ----------------------------------------------------------------------------
module tfhq_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  tfhq_pkg::tfhq_stat_t stat,
    output tfhq_pkg::tfhq_cmd_t  cmd
);

    typedef enum logic [5:0] {
        ST_IDLE, ST_PREP, ST_MX, ST_MY, ST_MGY, ST_BOX,
        ST_N0, ST_N1, ST_N2, ST_N3, ST_N4, ST_N5, ST_NZ,
        ST_MAG, ST_SHIFT, ST_SQX, ST_SQY, ST_SQZ, ST_SL0, ST_SL1,
        ST_D0, ST_D1, ST_DET, ST_DCHK, ST_U1, ST_UN, ST_V1, ST_VN,
        ST_DIVU, ST_WAITU, ST_DIVV, ST_WAITV, ST_BARY,
        ST_H0, ST_H1, ST_H2, ST_H3, ST_H4, ST_UPD, ST_END
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (s_tvalid) state_next = ST_PREP;
            ST_PREP:  state_next = ST_MX;
            ST_MX:    state_next = ST_MY;
            ST_MY:    state_next = ST_MGY;
            ST_MGY:   state_next = ST_BOX;
            ST_BOX:   state_next = stat.fail ? ST_END : ST_N0;
            ST_N0:    state_next = ST_N1;
            ST_N1:    state_next = ST_N2;
            ST_N2:    state_next = ST_N3;
            ST_N3:    state_next = ST_N4;
            ST_N4:    state_next = ST_N5;
            ST_N5:    state_next = ST_NZ;
            ST_NZ:    state_next = ST_MAG;
            ST_MAG:   state_next = ST_SHIFT;
            ST_SHIFT: if (stat.shift_done) state_next = ST_SQX;
            ST_SQX:   state_next = ST_SQY;
            ST_SQY:   state_next = ST_SQZ;
            ST_SQZ:   state_next = ST_SL0;
            ST_SL0:   state_next = ST_SL1;
            ST_SL1:   state_next = stat.fail ? ST_END : ST_D0;
            ST_D0:    state_next = ST_D1;
            ST_D1:    state_next = ST_DET;
            ST_DET:   state_next = ST_DCHK;
            ST_DCHK:  state_next = stat.fail ? ST_END : ST_U1;
            ST_U1:    state_next = ST_UN;
            ST_UN:    state_next = ST_V1;
            ST_V1:    state_next = ST_VN;
            ST_VN:    state_next = ST_DIVU;
            ST_DIVU:  state_next = ST_WAITU;
            ST_WAITU: if (stat.div_done) state_next = ST_DIVV;
            ST_DIVV:  state_next = ST_WAITV;
            ST_WAITV: if (stat.div_done) state_next = ST_BARY;
            ST_BARY:  state_next = stat.fail ? ST_END : ST_H0;
            ST_H0:    state_next = ST_H1;
            ST_H1:    state_next = ST_H2;
            ST_H2:    state_next = ST_H3;
            ST_H3:    state_next = ST_H4;
            ST_H4:    state_next = ST_UPD;
            ST_UPD:   state_next = ST_END;
            // a last word waits here until the output register is free
            ST_END:   if (!stat.last || !stat.out_busy) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        cmd.load = (state_reg == ST_IDLE) && s_tvalid;
        unique case (state_reg)
            ST_IDLE:  cmd.op = tfhq_pkg::OP_IDLE;
            ST_PREP:  cmd.op = tfhq_pkg::OP_PREP;
            ST_MX:    cmd.op = tfhq_pkg::OP_MX;
            ST_MY:    cmd.op = tfhq_pkg::OP_MY;
            ST_MGY:   cmd.op = tfhq_pkg::OP_MGY;
            ST_BOX:   cmd.op = tfhq_pkg::OP_BOX;
            ST_N0:    cmd.op = tfhq_pkg::OP_N0;
            ST_N1:    cmd.op = tfhq_pkg::OP_N1;
            ST_N2:    cmd.op = tfhq_pkg::OP_N2;
            ST_N3:    cmd.op = tfhq_pkg::OP_N3;
            ST_N4:    cmd.op = tfhq_pkg::OP_N4;
            ST_N5:    cmd.op = tfhq_pkg::OP_N5;
            ST_NZ:    cmd.op = tfhq_pkg::OP_NZ;
            ST_MAG:   cmd.op = tfhq_pkg::OP_MAG;
            ST_SHIFT: cmd.op = tfhq_pkg::OP_SHIFT;
            ST_SQX:   cmd.op = tfhq_pkg::OP_SQX;
            ST_SQY:   cmd.op = tfhq_pkg::OP_SQY;
            ST_SQZ:   cmd.op = tfhq_pkg::OP_SQZ;
            ST_SL0:   cmd.op = tfhq_pkg::OP_SL0;
            ST_SL1:   cmd.op = tfhq_pkg::OP_SL1;
            ST_D0:    cmd.op = tfhq_pkg::OP_D0;
            ST_D1:    cmd.op = tfhq_pkg::OP_D1;
            ST_DET:   cmd.op = tfhq_pkg::OP_DET;
            ST_DCHK:  cmd.op = tfhq_pkg::OP_DCHK;
            ST_U1:    cmd.op = tfhq_pkg::OP_U1;
            ST_UN:    cmd.op = tfhq_pkg::OP_UN;
            ST_V1:    cmd.op = tfhq_pkg::OP_V1;
            ST_VN:    cmd.op = tfhq_pkg::OP_VN;
            ST_DIVU:  cmd.op = tfhq_pkg::OP_DIVU;
            ST_WAITU: cmd.op = tfhq_pkg::OP_WAITU;
            ST_DIVV:  cmd.op = tfhq_pkg::OP_DIVV;
            ST_WAITV: cmd.op = tfhq_pkg::OP_WAITV;
            ST_BARY:  cmd.op = tfhq_pkg::OP_BARY;
            ST_H0:    cmd.op = tfhq_pkg::OP_H0;
            ST_H1:    cmd.op = tfhq_pkg::OP_H1;
            ST_H2:    cmd.op = tfhq_pkg::OP_H2;
            ST_H3:    cmd.op = tfhq_pkg::OP_H3;
            ST_H4:    cmd.op = tfhq_pkg::OP_H4;
            ST_UPD:   cmd.op = tfhq_pkg::OP_UPD;
            ST_END:   cmd.op = tfhq_pkg::OP_END;
            default:  cmd.op = tfhq_pkg::OP_IDLE;
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE);

endmodule

// File: src/tfhq_dp.sv
// ----------------------------------------------------------------------------
// tfhq_dp
// Datapath: input and configuration registers, one shared 33x33 multiplier,
// the serial divider, the four triangle tests, height interpolation, the
// running best floor and the output register.
// ----------------------------------------------------------------------------
module tfhq_dp (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  tfhq_pkg::tfhq_cmd_t  cmd,
    output tfhq_pkg::tfhq_stat_t stat,
    input  logic [287:0]         s_tdata,
    input  logic                 s_tlast,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_index,
    input  logic [31:0]          cfg_data,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [31:0]          m_tdata,
    output logic [0:0]           m_tuser
);

    // configuration
    logic signed [31:0] qx_reg, qy_reg, wtop_reg, wbot_reg;

    // triangle
    logic signed [31:0] ax_reg, ay_reg, az_reg, bx_reg, by_reg, bz_reg;
    logic signed [31:0] cx_reg, cy_reg, cz_reg;
    logic               last_reg;

    // differences, saturated except the exact 33-bit azcz and bzcz
    logic signed [31:0] abx_reg, aby_reg, abz_reg, acx_reg, acy_reg, acz_reg;
    logic signed [31:0] bcy_reg, axcx_reg, cxbx_reg, aycy_reg;
    logic signed [31:0] qxcx_reg, qycy_reg, cyay_reg;
    logic signed [32:0] azcz_reg, bzcz_reg;

    // bounding box
    logic signed [31:0] lox_reg, hix_reg, loy_reg, hiy_reg;
    logic [28:0]        sx3_reg, sy3_reg;
    logic [19:0]        mgx_reg, mgy_reg;

    // products and intermediates
    logic signed [65:0] p_reg;
    logic signed [63:0] t_reg;
    logic signed [63:0] nx_reg, ny_reg, nz_reg;
    logic [63:0]        mx_reg, my_reg, mz_reg;
    logic [57:0]        sq_reg;
    logic [62:0]        z29_reg, s21_reg;
    logic signed [63:0] det_reg, un_reg, vn_reg;
    logic signed [33:0] u_reg, w_reg;
    logic signed [64:0] s_reg;
    logic signed [34:0] r_reg;
    logic signed [31:0] h_reg;

    // query state and output
    logic signed [31:0] best_reg;
    logic               any_reg;
    logic               m_valid_reg;
    logic               m_found_reg;
    logic signed [31:0] m_height_reg;

    logic signed [32:0] mul_a, mul_b;
    logic signed [31:0] lox_c, hix_c, loy_c, hiy_c;
    logic [32:0]        spx, spy;
    logic signed [33:0] qx_e, qy_e, mgx_e, mgy_e;
    logic               box_fail, slope_fail, det_fail, bary_fail;
    logic               big, any_hi;
    logic signed [34:0] u_e, w_e;
    logic signed [64:0] rnd;
    logic signed [35:0] hs;
    logic signed [31:0] floor_now;
    logic               out_busy;
    logic               finish;
    logic               found;
    logic               div_start, div_done;
    logic signed [33:0] div_quot;
    logic [62:0]        pz, sqe;
    tfhq_pkg::tfhq_op_t op;

    assign op = cmd.op;

    // ---------------------------------------------------------------- config
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            qx_reg   <= '0;
            qy_reg   <= '0;
            wtop_reg <= '0;
            wbot_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                tfhq_pkg::REG_QUERY_X:       qx_reg   <= cfg_data;
                tfhq_pkg::REG_QUERY_Y:       qy_reg   <= cfg_data;
                tfhq_pkg::REG_WINDOW_TOP:    wtop_reg <= cfg_data;
                tfhq_pkg::REG_WINDOW_BOTTOM: wbot_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------- combinational
    always_comb begin
        lox_c = (ax_reg < bx_reg) ? ax_reg : bx_reg;
        if (cx_reg < lox_c) lox_c = cx_reg;
        hix_c = (ax_reg > bx_reg) ? ax_reg : bx_reg;
        if (cx_reg > hix_c) hix_c = cx_reg;
        loy_c = (ay_reg < by_reg) ? ay_reg : by_reg;
        if (cy_reg < loy_c) loy_c = cy_reg;
        hiy_c = (ay_reg > by_reg) ? ay_reg : by_reg;
        if (cy_reg > hiy_c) hiy_c = cy_reg;
        spx = 33'(hix_c) - 33'(lox_c);
        spy = 33'(hiy_c) - 33'(loy_c);
    end

    always_comb begin
        qx_e  = 34'(qx_reg);
        qy_e  = 34'(qy_reg);
        mgx_e = $signed({14'b0, mgx_reg});
        mgy_e = $signed({14'b0, mgy_reg});
        box_fail = (qx_e + mgx_e < 34'(lox_reg)) || (qx_e - mgx_e > 34'(hix_reg))
                || (qy_e + mgy_e < 34'(loy_reg)) || (qy_e - mgy_e > 34'(hiy_reg));
        slope_fail = (z29_reg < s21_reg);
        det_fail   = (det_reg < tfhq_pkg::DET_MIN) && (det_reg > -tfhq_pkg::DET_MIN);
        u_e = 35'(u_reg);
        w_e = 35'(w_reg);
        bary_fail = (u_e < -tfhq_pkg::BARY_TOL) || (w_e < -tfhq_pkg::BARY_TOL)
                 || (u_e + w_e > tfhq_pkg::Q30_ONE + tfhq_pkg::BARY_TOL);
        big    = (|mx_reg[63:36]) || (|my_reg[63:36]) || (|mz_reg[63:36]);
        any_hi = (|mx_reg[63:28]) || (|my_reg[63:28]) || (|mz_reg[63:28]);
        pz  = 63'(p_reg[55:0]);
        sqe = 63'(sq_reg);
        rnd = s_reg + tfhq_pkg::Q30_HALF;
        hs  = 36'(cz_reg) + 36'(r_reg);
        floor_now = any_reg ? best_reg : wbot_reg;
        found = any_reg && !(wtop_reg < wbot_reg);
    end

    always_comb begin
        stat.fail       = 1'b0;
        stat.shift_done = !any_hi;
        stat.div_done   = div_done;
        stat.last       = last_reg;
        stat.out_busy   = out_busy;
        case (op)
            tfhq_pkg::OP_BOX:  stat.fail = box_fail;
            tfhq_pkg::OP_SL1:  stat.fail = slope_fail;
            tfhq_pkg::OP_DCHK: stat.fail = det_fail;
            tfhq_pkg::OP_BARY: stat.fail = bary_fail;
            default:           stat.fail = 1'b0;
        endcase
    end

    // multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (op)
            tfhq_pkg::OP_MX: begin
                mul_a = $signed({4'b0, sx3_reg});
                mul_b = $signed({3'b0, tfhq_pkg::MARGIN_MUL});
            end
            tfhq_pkg::OP_MY: begin
                mul_a = $signed({4'b0, sy3_reg});
                mul_b = $signed({3'b0, tfhq_pkg::MARGIN_MUL});
            end
            tfhq_pkg::OP_N0: begin mul_a = 33'(aby_reg); mul_b = 33'(acz_reg); end
            tfhq_pkg::OP_N1: begin mul_a = 33'(abz_reg); mul_b = 33'(acy_reg); end
            tfhq_pkg::OP_N2: begin mul_a = 33'(abz_reg); mul_b = 33'(acx_reg); end
            tfhq_pkg::OP_N3: begin mul_a = 33'(abx_reg); mul_b = 33'(acz_reg); end
            tfhq_pkg::OP_N4: begin mul_a = 33'(abx_reg); mul_b = 33'(acy_reg); end
            tfhq_pkg::OP_N5: begin mul_a = 33'(aby_reg); mul_b = 33'(acx_reg); end
            tfhq_pkg::OP_SQX: begin
                mul_a = $signed({5'b0, mx_reg[27:0]});
                mul_b = $signed({5'b0, mx_reg[27:0]});
            end
            tfhq_pkg::OP_SQY: begin
                mul_a = $signed({5'b0, my_reg[27:0]});
                mul_b = $signed({5'b0, my_reg[27:0]});
            end
            tfhq_pkg::OP_SQZ: begin
                mul_a = $signed({5'b0, mz_reg[27:0]});
                mul_b = $signed({5'b0, mz_reg[27:0]});
            end
            tfhq_pkg::OP_D0:   begin mul_a = 33'(bcy_reg);  mul_b = 33'(axcx_reg); end
            tfhq_pkg::OP_D1:   begin mul_a = 33'(cxbx_reg); mul_b = 33'(aycy_reg); end
            tfhq_pkg::OP_DCHK: begin mul_a = 33'(bcy_reg);  mul_b = 33'(qxcx_reg); end
            tfhq_pkg::OP_U1:   begin mul_a = 33'(cxbx_reg); mul_b = 33'(qycy_reg); end
            tfhq_pkg::OP_UN:   begin mul_a = 33'(cyay_reg); mul_b = 33'(qxcx_reg); end
            tfhq_pkg::OP_V1:   begin mul_a = 33'(axcx_reg); mul_b = 33'(qycy_reg); end
            // barycentrics are within about +-1.0003 here after the inside test
            tfhq_pkg::OP_H0:   begin mul_a = u_reg[32:0]; mul_b = azcz_reg; end
            tfhq_pkg::OP_H1:   begin mul_a = w_reg[32:0]; mul_b = bzcz_reg; end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign div_start = (op == tfhq_pkg::OP_DIVU) || (op == tfhq_pkg::OP_DIVV);

    tfhq_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     ((op == tfhq_pkg::OP_DIVV) ? vn_reg : un_reg),
        .den     (det_reg),
        .done    (div_done),
        .quot    (div_quot)
    );

    // ------------------------------------------------------------- datapath
    always_ff @(posedge aclk) begin
        p_reg <= mul_a * mul_b;

        if (cmd.load) begin
            ax_reg   <= s_tdata[31:0];
            ay_reg   <= s_tdata[63:32];
            az_reg   <= s_tdata[95:64];
            bx_reg   <= s_tdata[127:96];
            by_reg   <= s_tdata[159:128];
            bz_reg   <= s_tdata[191:160];
            cx_reg   <= s_tdata[223:192];
            cy_reg   <= s_tdata[255:224];
            cz_reg   <= s_tdata[287:256];
            last_reg <= s_tlast;
        end

        case (op) inside
            tfhq_pkg::OP_PREP: begin
                abx_reg  <= tfhq_pkg::dsat(bx_reg, ax_reg);
                aby_reg  <= tfhq_pkg::dsat(by_reg, ay_reg);
                abz_reg  <= tfhq_pkg::dsat(bz_reg, az_reg);
                acx_reg  <= tfhq_pkg::dsat(cx_reg, ax_reg);
                acy_reg  <= tfhq_pkg::dsat(cy_reg, ay_reg);
                acz_reg  <= tfhq_pkg::dsat(cz_reg, az_reg);
                bcy_reg  <= tfhq_pkg::dsat(by_reg, cy_reg);
                axcx_reg <= tfhq_pkg::dsat(ax_reg, cx_reg);
                cxbx_reg <= tfhq_pkg::dsat(cx_reg, bx_reg);
                aycy_reg <= tfhq_pkg::dsat(ay_reg, cy_reg);
                qxcx_reg <= tfhq_pkg::dsat(qx_reg, cx_reg);
                qycy_reg <= tfhq_pkg::dsat(qy_reg, cy_reg);
                cyay_reg <= tfhq_pkg::dsat(cy_reg, ay_reg);
                azcz_reg <= 33'(az_reg) - 33'(cz_reg);
                bzcz_reg <= 33'(bz_reg) - 33'(cz_reg);
                lox_reg  <= lox_c;
                hix_reg  <= hix_c;
                loy_reg  <= loy_c;
                hiy_reg  <= hiy_c;
                sx3_reg  <= spx[31:3];
                sy3_reg  <= spy[31:3];
            end
            tfhq_pkg::OP_MY:  mgx_reg <= p_reg[58:39] + tfhq_pkg::MARGIN_ABS;
            tfhq_pkg::OP_MGY: mgy_reg <= p_reg[58:39] + tfhq_pkg::MARGIN_ABS;
            tfhq_pkg::OP_N1, tfhq_pkg::OP_N3, tfhq_pkg::OP_N5,
            tfhq_pkg::OP_D1, tfhq_pkg::OP_U1, tfhq_pkg::OP_V1,
            tfhq_pkg::OP_H1:  t_reg <= p_reg[63:0];
            tfhq_pkg::OP_N2:  nx_reg <= t_reg - $signed(p_reg[63:0]);
            tfhq_pkg::OP_N4:  ny_reg <= t_reg - $signed(p_reg[63:0]);
            tfhq_pkg::OP_NZ:  nz_reg <= t_reg - $signed(p_reg[63:0]);
            tfhq_pkg::OP_MAG: begin
                mx_reg <= tfhq_pkg::mag64(nx_reg);
                my_reg <= tfhq_pkg::mag64(ny_reg);
                mz_reg <= tfhq_pkg::mag64(nz_reg);
            end
            tfhq_pkg::OP_SHIFT: begin
                // coarse steps of 8 while any is still at or above 2^36, then single bits
                if (big) begin
                    mx_reg <= mx_reg >> 8;
                    my_reg <= my_reg >> 8;
                    mz_reg <= mz_reg >> 8;
                end else if (any_hi) begin
                    mx_reg <= mx_reg >> 1;
                    my_reg <= my_reg >> 1;
                    mz_reg <= mz_reg >> 1;
                end
            end
            tfhq_pkg::OP_SQY: sq_reg <= p_reg[57:0];
            tfhq_pkg::OP_SQZ: sq_reg <= sq_reg + p_reg[57:0];
            tfhq_pkg::OP_SL0: begin
                z29_reg <= (pz << 4) + (pz << 3) + (pz << 2) + pz;
                s21_reg <= (sqe << 4) + (sqe << 2) + sqe;
            end
            tfhq_pkg::OP_DET: det_reg <= t_reg + $signed(p_reg[63:0]);
            tfhq_pkg::OP_UN:  un_reg  <= t_reg + $signed(p_reg[63:0]);
            tfhq_pkg::OP_VN:  vn_reg  <= t_reg + $signed(p_reg[63:0]);
            tfhq_pkg::OP_WAITU: if (div_done) u_reg <= div_quot;
            tfhq_pkg::OP_WAITV: if (div_done) w_reg <= div_quot;
            tfhq_pkg::OP_H2:  s_reg <= 65'(t_reg) + 65'($signed(p_reg[63:0]));
            tfhq_pkg::OP_H3:  r_reg <= rnd[64:30];
            tfhq_pkg::OP_H4: begin
                if (hs > 36'sd2147483647) begin
                    h_reg <= 32'sh7fffffff;
                end else if (hs < -36'sd2147483648) begin
                    h_reg <= 32'sh80000000;
                end else begin
                    h_reg <= hs[31:0];
                end
            end
            default: ;
        endcase
    end

    // ---------------------------------------------------- best floor, output
    assign out_busy = m_valid_reg && !m_tready;
    assign finish   = (op == tfhq_pkg::OP_END) && last_reg && !out_busy;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            any_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (op == tfhq_pkg::OP_UPD) begin
                if ((h_reg <= wtop_reg) && (h_reg >= floor_now)) begin
                    best_reg <= h_reg;
                    any_reg  <= 1'b1;
                end
            end
            if (finish) begin
                m_valid_reg  <= 1'b1;
                m_found_reg  <= found;
                m_height_reg <= found ? best_reg : wbot_reg;
                any_reg      <= 1'b0;
                best_reg     <= wbot_reg;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_height_reg;
    assign m_tuser  = m_found_reg;

endmodule

// File: src/triangle_floor_height_query.sv
// ----------------------------------------------------------------------------
// triangle_floor_height_query
// Highest walkable floor under a query point over a stream of triangles.
//
// Set query_x/query_y and the height window through the cfg port while idle.
// Each s_ word is one candidate triangle (nine Q16.16 coordinates); tlast
// marks the final triangle of a query. Each triangle is box tested, slope
// tested, determinant tested, then its barycentrics are found by a serial
// divider and the interpolated height updates the running best floor.
// The final triangle produces one m_ word: tuser = found, tdata = height
// (window_bottom when nothing was found); the query state then clears.
// A new word is taken only when the previous one is through; the time
// a word takes is set by the two divisions in the serial divider plus
// the normal shift loop and the single shared multiplier; a rejected
// triangle leaves early (soonest after a box miss). The result is
// registered as the last word finishes. A stalled m_ side holds the
// result in the output register; only a further last word waits for it.
// Reset clears the query state, output valid and cfg registers to zero.
// ----------------------------------------------------------------------------
module triangle_floor_height_query (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // vertex_a_x, vertex_a_y, vertex_a_z, vertex_b_x, vertex_b_y, vertex_b_z,
    // vertex_c_x, vertex_c_y, vertex_c_z (32 bits each, lowest first)
    input  logic [287:0] s_tdata,
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    // floor_height
    output logic [31:0]  m_tdata,
    // floor_found
    output logic [0:0]   m_tuser,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    tfhq_pkg::tfhq_cmd_t  cmd;
    tfhq_pkg::tfhq_stat_t stat;

    tfhq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    tfhq_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Floor height query testbench: a directed table of triangles, then random
// queries, all checked word by word against a local predictor of the block.
// ----------------------------------------------------------------------------
module tb;

    localparam int N_RANDOM = 730;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [287:0] s_tdata = '0;
    logic         s_tlast = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [31:0]  m_tdata;
    logic [0:0]   m_tuser;
    logic         cfg_we = 1'b0;
    logic [1:0]   cfg_index = '0;
    logic [31:0]  cfg_data = '0;

    always #2 aclk = ~aclk;

    triangle_floor_height_query u_dut (.*);

    typedef struct {
        logic        found;
        logic [31:0] height;
    } floor_t;

    typedef struct {
        logic signed [31:0] v [9];
        logic               last;
        logic               has_exp;
        logic               exp_found;
        logic [31:0]        exp_height;
    } tri_row_t;

    // predictor state
    logic signed [31:0] qx, qy, wtop, wbot;
    logic signed [31:0] best_z;
    logic               hit;

    floor_t floors_due [$];
    int     n_err = 0;
    int     n_words = 0;
    int     n_results = 0;
    int     n_found = 0;
    logic   noisy_recv = 1'b1;
    logic   hold_recv = 1'b0;

    function automatic logic signed [63:0] ds(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
        logic signed [63:0] d;
        d = 64'(a) - 64'(b);
        if (d > 64'sd2147483647) d = 64'sd2147483647;
        if (d < -64'sd2147483647) d = -64'sd2147483647;
        return d;
    endfunction

    function automatic logic box_ok(input logic signed [31:0] a, b, c, at);
        logic signed [63:0] lo, hi, mg;
        lo = a; hi = a;
        if (b < lo) lo = b;
        if (c < lo) lo = c;
        if (b > hi) hi = b;
        if (c > hi) hi = c;
        mg = (hi - lo) / 5000 + 655;
        return !(64'(at) < lo - mg || 64'(at) > hi + mg);
    endfunction

    function automatic logic [63:0] absv(input logic signed [63:0] v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    // Q.30 quotient, truncated, magnitude capped at 4.0
    function automatic logic signed [63:0] q30_div(input logic signed [63:0] num,
                                                   input logic signed [63:0] den);
        logic        neg;
        logic [63:0] n, d, q, r;
        neg = (num < 0) != (den < 0);
        n = absv(num); d = absv(den);
        if (d == 0 || (d <= (64'hFFFF_FFFF_FFFF_FFFF >> 2) && n >= (d << 2))) begin
            q = 64'd4 << 30;
        end else begin
            q = n / d; r = n % d;
            for (int i = 0; i < 30; i++) begin
                r = r << 1; q = q << 1;
                if (r >= d) begin
                    r = r - d; q[0] = 1'b1;
                end
            end
        end
        return neg ? -$signed(q) : $signed(q);
    endfunction

    function automatic logic tri_floor(input logic signed [31:0] v [9],
                                       output logic signed [31:0] h);
        logic signed [63:0] abx, aby, abz, acx, acy, acz, nx, ny, nz, det, un, vn;
        logic signed [63:0] u, w, t;
        logic signed [127:0] s;
        logic [63:0] mx, my, mz;
        h = '0;
        if (!box_ok(v[0], v[3], v[6], qx) || !box_ok(v[1], v[4], v[7], qy)) return 0;
        abx = ds(v[3], v[0]); aby = ds(v[4], v[1]); abz = ds(v[5], v[2]);
        acx = ds(v[6], v[0]); acy = ds(v[7], v[1]); acz = ds(v[8], v[2]);
        nx = aby * acz - abz * acy;
        ny = abz * acx - abx * acz;
        nz = abx * acy - aby * acx;
        mx = absv(nx); my = absv(ny); mz = absv(nz);
        while (mx >= 64'd1 << 28 || my >= 64'd1 << 28 || mz >= 64'd1 << 28) begin
            mx = mx >> 1; my = my >> 1; mz = mz >> 1;
        end
        if (29 * mz * mz < 21 * (mx * mx + my * my)) return 0;
        det = ds(v[4], v[7]) * ds(v[0], v[6]) + ds(v[6], v[3]) * ds(v[1], v[7]);
        if (det < 42950 && det > -42950) return 0;
        un = ds(v[4], v[7]) * ds(qx, v[6]) + ds(v[6], v[3]) * ds(qy, v[7]);
        vn = ds(v[7], v[1]) * ds(qx, v[6]) + ds(v[0], v[6]) * ds(qy, v[7]);
        u = q30_div(un, det);
        w = q30_div(vn, det);
        if (u < -107374 || w < -107374 || u + w > (64'sd1 <<< 30) + 107374) return 0;
        s = 128'(u) * 128'(64'(v[2]) - 64'(v[8])) + 128'(w) * 128'(64'(v[5]) - 64'(v[8]))
            + (128'sd1 <<< 29);
        t = 64'(v[8]) + 64'(s >>> 30);
        if (t > 64'sd2147483647) t = 64'sd2147483647;
        if (t < -64'sd2147483648) t = -64'sd2147483648;
        h = t[31:0];
        return 1;
    endfunction

    // returns 1 when the triangle closes a query
    function automatic logic floor_step(input logic signed [31:0] v [9],
                                        input logic last, output floor_t res);
        logic signed [31:0] h, lim;
        res.found = 0; res.height = '0;
        if (tri_floor(v, h)) begin
            lim = hit ? best_z : wbot;
            if (h <= wtop && h >= lim) begin
                best_z = h; hit = 1;
            end
        end
        if (!last) return 0;
        res.found = hit && !(wtop < wbot);
        res.height = res.found ? best_z : wbot;
        hit = 0; best_z = wbot;
        return 1;
    endfunction

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
        @(negedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            tfhq_pkg::REG_QUERY_X:       qx = val;
            tfhq_pkg::REG_QUERY_Y:       qy = val;
            tfhq_pkg::REG_WINDOW_TOP:    wtop = val;
            tfhq_pkg::REG_WINDOW_BOTTOM: wbot = val;
        endcase
    endtask

    task automatic set_query(input logic [31:0] x, y, top, bot);
        write_reg(tfhq_pkg::REG_QUERY_X, x);
        write_reg(tfhq_pkg::REG_QUERY_Y, y);
        write_reg(tfhq_pkg::REG_WINDOW_TOP, top);
        write_reg(tfhq_pkg::REG_WINDOW_BOTTOM, bot);
    endtask

    // wait until idle; a rejected-early word may still be in flight
    task automatic drain_floors();
        // back-to-back words leave tvalid up; drop it while waiting
        s_tvalid <= 1'b0;
        while (floors_due.size() != 0) @(negedge aclk);
        repeat (150) @(negedge aclk);
    endtask

    task automatic send_tri(input logic signed [31:0] v [9], input logic last,
                            input logic gaps);
        floor_t       r;
        logic [287:0] word;
        for (int i = 0; i < 9; i++) word[32*i +: 32] = v[i];
        while (gaps && $urandom_range(99) < 9) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tdata <= word;
        s_tlast <= last;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (floor_step(v, last, r)) floors_due.push_back(r);
        n_words++;
        @(negedge aclk);
    endtask

    // result checker
    always @(posedge aclk) begin
        floor_t e;
        if (aresetn && m_tvalid && m_tready) begin
            n_results++;
            if (floors_due.size() == 0) begin
                $error("unexpected result word: found=%0d height=%h", m_tuser, m_tdata);
                n_err++;
            end else begin
                e = floors_due.pop_front();
                if (e.found) n_found++;
                if (m_tuser[0] !== e.found) begin
                    $error("floor_found exp %0d got %0d", e.found, m_tuser[0]);
                    n_err++;
                end
                if (m_tdata !== e.height) begin
                    $error("floor_height exp %h got %h", e.height, m_tdata);
                    n_err++;
                end
            end
        end
    end

    // receiver: random stalls, or a long counted hold-off on request
    always @(negedge aclk) begin
        if (hold_recv) m_tready <= 1'b0;
        else if (noisy_recv) m_tready <= ($urandom_range(99) >= 9);
        else m_tready <= 1'b1;
    end

    function automatic logic signed [31:0] rnd_coord(input int spread);
        return $signed(32'($urandom_range(2 * spread))) - spread;
    endfunction

    // random walkable-ish triangle around the query point, or a fully random one
    task automatic make_tri(output logic signed [31:0] v [9]);
        int kind, sp;
        kind = $urandom_range(9);
        sp = (kind < 3) ? 32'h0001_0000 : (kind < 7) ? 32'h0010_0000 : 32'h1000_0000;
        for (int i = 0; i < 3; i++) begin
            v[3*i]     = qx + rnd_coord(sp);
            v[3*i + 1] = qy + rnd_coord(sp);
            v[3*i + 2] = rnd_coord(sp >> ($urandom_range(1) * 3));
        end
        if (kind == 9) for (int i = 0; i < 9; i++) v[i] = $urandom;
        if (kind == 8) begin
            // degenerate: all vertices on one line
            v[6] = v[0]; v[7] = v[1];
        end
    endtask

    initial begin
        tri_row_t rows [$];
        tri_row_t rw;
        logic signed [31:0] v [9];
        int qlen;

        qx = 0; qy = 0; wtop = 0; wbot = 0; best_z = 0; hit = 0;
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed table; unit is 1.0 = 32'h10000
        rw.has_exp = 0;
        // lone last word after reset: window 0..0, nothing found
        rw.v = '{0, 0, 0, 0, 0, 0, 0, 0, 0}; rw.last = 1;
        rw.has_exp = 1; rw.exp_found = 0; rw.exp_height = 0; rows.push_back(rw);
        // flat floor at z=0 under the origin, fits window 0..0
        rw.v = '{-32'sh10000, -32'sh10000, 0, 32'sh20000, -32'sh10000, 0,
                 -32'sh10000, 32'sh20000, 0}; rw.last = 1;
        rw.exp_found = 1; rw.exp_height = 0; rows.push_back(rw);
        rw.has_exp = 0;
        // vertical wall, too steep
        rw.v = '{-32'sh10000, 0, 0, 32'sh10000, 0, 0, 0, 0, 32'sh10000}; rw.last = 0;
        rows.push_back(rw);
        // query point outside the triangle
        rw.v = '{32'sh50000, 32'sh50000, 0, 32'sh60000, 32'sh50000, 0,
                 32'sh50000, 32'sh60000, 0}; rows.push_back(rw);
        // extremes: huge coordinates, saturating differences
        rw.v = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                 32'h7FFF_FFFF}; rows.push_back(rw);
        rw.v = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                 32'h7FFF_FFFF}; rows.push_back(rw);
        rw.v = '{-1, -1, -1, -1, -1, -1, -1, -1, -1}; rows.push_back(rw);
        // degenerate sliver
        rw.v = '{-32'sh10000, 0, 0, 32'sh10000, 0, 0, 0, 1, 0}; rows.push_back(rw);
        // sloped floor, equal height three times
        rw.v = '{-32'sh10000, -32'sh10000, -32'sh4000, 32'sh20000, -32'sh10000,
                 32'sh4000, -32'sh10000, 32'sh20000, 0}; rows.push_back(rw);
        rows.push_back(rw);
        rw.last = 1; rows.push_back(rw);

        foreach (rows[i]) begin
            if (i == 2) begin
                drain_floors();
                set_query(0, 0, 32'sh7FFF_FFFF, 32'h8000_0000);
            end
            send_tri(rows[i].v, rows[i].last, 0);
            if (rows[i].has_exp && floors_due.size() != 0 &&
                (floors_due[$].found !== rows[i].exp_found ||
                 floors_due[$].height !== rows[i].exp_height)) begin
                $error("table row %0d: predictor disagrees with typed result", i);
                n_err++;
            end
        end

        // inverted window
        drain_floors();
        set_query(0, 0, -32'sh10000, 32'sh10000);
        rw.v = rows[1].v;
        send_tri(rw.v, 1, 0);

        // hold off the receiver while several results pile up
        drain_floors();
        set_query(0, 0, 32'sh7FFF_FFFF, 32'h8000_0000);
        hold_recv = 1'b1;
        fork
            begin
                for (int k = 0; k < 6; k++) send_tri(rows[1].v, 1, 0);
            end
            begin
                repeat (1500) @(negedge aclk);
                hold_recv = 1'b0;
            end
        join

        // random queries; one stretch with no idling on either side
        for (int n = 0; n < N_RANDOM; ) begin
            drain_floors();
            case ($urandom_range(5))
                0: set_query($urandom, $urandom, $urandom, $urandom);
                1: set_query(0, 0, 32'h7FFF_FFFF, 32'h8000_0000);
                default: set_query(rnd_coord(32'h0100_0000), rnd_coord(32'h0100_0000),
                                   32'sh0008_0000, -32'sh0008_0000);
            endcase
            noisy_recv = !(n > 300 && n < 420);
            qlen = $urandom_range(1, 8);
            for (int k = 0; k < qlen; k++) begin
                make_tri(v);
                send_tri(v, k == qlen - 1 || $urandom_range(19) == 0, noisy_recv);
                n++;
            end
        end

        drain_floors();
        $display("covered %0d triangle words, %0d query results (%0d with a floor)",
                 n_words, n_results, n_found);
        if (n_err == 0) begin
            $display("triangle_floor_height_query test passed");
        end else begin
            $display("triangle_floor_height_query test failed");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("triangle_floor_height_query test failed");
        $finish;
    end

endmodule

// File: triangle_floor_height_query.f
src/tfhq_pkg.sv
src/tfhq_div.sv
src/tfhq_ctrl.sv
src/tfhq_dp.sv
src/triangle_floor_height_query.sv
tb/sv/tb.sv
